// File: rtl/core/pfd_pkg.sv
`timescale 1ns / 1ps

package pfd_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORD_W    = 32;
  localparam int UWORD_W   = 31;

  localparam logic [UWORD_W-1:0] TS_RESET = 31'd1092;
  localparam logic [FRAC_BITS:0] ONE_Q    = 17'h10000;
  localparam logic [17:0]        THREE_Q  = 18'd196608;
  localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fffffff;
  localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh80000000;

  typedef struct packed {
    logic signed [WORD_W-1:0] pos_x;
    logic signed [WORD_W-1:0] pos_y;
    logic signed [WORD_W-1:0] pos_z;
    logic signed [WORD_W-1:0] vel_x;
    logic signed [WORD_W-1:0] vel_y;
    logic signed [WORD_W-1:0] vel_z;
    logic signed [WORD_W-1:0] angle;
    logic signed [WORD_W-1:0] spin_rate;
    logic signed [WORD_W-1:0] age;
    logic [UWORD_W-1:0]       life;
    logic [UWORD_W-1:0]       start_size;
    logic [UWORD_W-1:0]       end_size;
  } in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] new_x;
    logic signed [WORD_W-1:0] new_y;
    logic signed [WORD_W-1:0] new_z;
    logic signed [WORD_W-1:0] new_angle;
    logic signed [WORD_W-1:0] new_age;
    logic                     keep;
    logic                     shown;
    logic [UWORD_W-1:0]       draw_size;
    logic [16:0]              alpha_scale;
  } out_t;

  // fields that ride alongside the divider
  typedef struct packed {
    logic signed [WORD_W-1:0] new_x;
    logic signed [WORD_W-1:0] new_y;
    logic signed [WORD_W-1:0] new_z;
    logic signed [WORD_W-1:0] new_angle;
    logic signed [WORD_W-1:0] new_age;
    logic                     keep;
    logic                     shown;
    logic [UWORD_W-1:0]       start_size;
    logic [UWORD_W-1:0]       end_size;
  } side_t;

endpackage

// File: rtl/core/pfd_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per stage, side payload carried along.
module pfd_div #(
  parameter int SIDE_W = 8,
  parameter int QW     = pfd_pkg::FRAC_BITS,
  parameter int DW     = pfd_pkg::UWORD_W
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [DW-1:0]     rem_i,
  input  logic [DW-1:0]     div_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [QW-1:0]     quo_o,
  output logic [SIDE_W-1:0] side_o
);

  logic              v_q [QW];
  logic [DW-1:0]     r_q [QW];
  logic [DW-1:0]     d_q [QW];
  logic [QW-1:0]     q_q [QW];
  logic [SIDE_W-1:0] s_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic              pv;
    logic [DW-1:0]     pr;
    logic [DW-1:0]     pd;
    logic [QW-1:0]     pq;
    logic [SIDE_W-1:0] ps;
    logic [DW:0]       r2;
    logic              bit_w;

    if (k == 0) begin : g_first
      assign pv = valid_i;
      assign pr = rem_i;
      assign pd = div_i;
      assign pq = '0;
      assign ps = side_i;
    end else begin : g_rest
      assign pv = v_q[k-1];
      assign pr = r_q[k-1];
      assign pd = d_q[k-1];
      assign pq = q_q[k-1];
      assign ps = s_q[k-1];
    end

    assign r2    = {pr, 1'b0};
    assign bit_w = (r2 >= {1'b0, pd});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k] <= bit_w ? DW'(r2 - {1'b0, pd}) : r2[DW-1:0];
        d_q[k] <= pd;
        q_q[k] <= {pq[QW-2:0], bit_w};
        s_q[k] <= ps;
      end
    end
  end

  assign valid_o = v_q[QW-1];
  assign quo_o   = q_q[QW-1];
  assign side_o  = s_q[QW-1];

endmodule

// File: rtl/core/particle_step_and_fade.sv
`timescale 1ns / 1ps

// Channel | Direction | Handshake             | Word
// in      | input     | in_valid_i / in_stall_o | pfd_pkg::in_t
// out     | output    | out_valid_o / out_stall_i | pfd_pkg::out_t
// cfg     | input     | cfg_valid_i / cfg_ready_o | time_step, 31 bit
//
// One word enters per cycle unless the output is stalled. Stages in order:
// age stage, motion multiply, motion add, 16 divider stages (one quotient
// bit each), then blend multiply, size and fade multiply, output register.
// Reset clears all valid bits and loads the time step with 1092.
// A stalled output freezes the whole pipeline; in_stall_o follows it.
module particle_step_and_fade (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  pfd_pkg::in_t                in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output pfd_pkg::out_t               out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [pfd_pkg::UWORD_W-1:0] cfg_data_i
);

  localparam int W  = pfd_pkg::WORD_W;
  localparam int UW = pfd_pkg::UWORD_W;
  localparam int FB = pfd_pkg::FRAC_BITS;

  logic [UW-1:0] ts_q;
  logic          en;

  // Advance everything unless a finished word is held at the output.
  assign en          = !(out_valid_o && out_stall_i);
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ts_q <= pfd_pkg::TS_RESET;
    end else if (cfg_valid_i) begin
      ts_q <= cfg_data_i;
    end
  end

  // ---------------- stage A: new age, active time ----------------
  logic signed [W:0]   age_sum;
  logic signed [W-1:0] new_age;
  logic signed [W-1:0] pos_new;
  logic signed [W-1:0] pos_old;
  logic signed [W-1:0] act_w;

  assign age_sum = {in_data_i.age[W-1], in_data_i.age} + $signed({2'b00, ts_q});
  // Time step is never negative: only the upper bound can be crossed.
  assign new_age = (age_sum[W] != age_sum[W-1]) ? pfd_pkg::WORD_MAX : age_sum[W-1:0];
  assign pos_new = new_age[W-1] ? '0 : new_age;
  assign pos_old = in_data_i.age[W-1] ? '0 : in_data_i.age;
  assign act_w   = pos_new - pos_old;

  logic                a_v_q;
  pfd_pkg::in_t        a_in_q;
  logic signed [W-1:0] a_age_q;
  logic [UW-1:0]       a_act_q;
  logic                a_keep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (en) begin
      a_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_in_q   <= in_data_i;
      a_age_q  <= new_age;
      a_act_q  <= act_w[UW-1:0];
      a_keep_q <= (new_age < $signed({1'b0, in_data_i.life}));
    end
  end

  // ---------------- stage B: rate times active time ----------------
  logic signed [W-1:0]   rate_w [4];
  logic signed [W-1:0]   base_w [4];
  logic signed [2*W-1:0] b_prod_q [4];
  logic signed [W-1:0]   b_base_q [4];
  logic                  b_v_q;
  logic signed [W-1:0]   b_age_q;
  logic                  b_keep_q;
  logic [UW-1:0]         b_life_q;
  logic [UW-1:0]         b_s0_q;
  logic [UW-1:0]         b_s1_q;

  assign rate_w[0] = a_in_q.vel_x;
  assign rate_w[1] = a_in_q.vel_y;
  assign rate_w[2] = a_in_q.vel_z;
  assign rate_w[3] = a_in_q.spin_rate;
  assign base_w[0] = a_in_q.pos_x;
  assign base_w[1] = a_in_q.pos_y;
  assign base_w[2] = a_in_q.pos_z;
  assign base_w[3] = a_in_q.angle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else if (en) begin
      b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        b_prod_q[k] <= (2*W)'(rate_w[k]) * (2*W)'($signed({1'b0, a_act_q}));
        b_base_q[k] <= base_w[k];
      end
      b_age_q  <= a_age_q;
      b_keep_q <= a_keep_q;
      b_life_q <= a_in_q.life;
      b_s0_q   <= a_in_q.start_size;
      b_s1_q   <= a_in_q.end_size;
    end
  end

  // ---------------- stage C: floor shift, add, saturate ----------------
  logic signed [W-1:0] sat_w [4];

  for (genvar k = 0; k < 4; k++) begin : g_mot
    logic signed [2*W-1:0] shp;
    logic signed [W+FB-1:0] sum;
    assign shp = b_prod_q[k] >>> FB;
    assign sum = (W+FB)'(b_base_q[k]) + shp[W+FB-1:0];
    always_comb begin
      if (sum > (W+FB)'(pfd_pkg::WORD_MAX)) begin
        sat_w[k] = pfd_pkg::WORD_MAX;
      end else if (sum < (W+FB)'(pfd_pkg::WORD_MIN)) begin
        sat_w[k] = pfd_pkg::WORD_MIN;
      end else begin
        sat_w[k] = sum[W-1:0];
      end
    end
  end

  logic           c_v_q;
  pfd_pkg::side_t c_side_q;
  logic [UW-1:0]  c_rem_q;
  logic [UW-1:0]  c_life_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q <= 1'b0;
    end else if (en) begin
      c_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_side_q.new_x      <= sat_w[0];
      c_side_q.new_y      <= sat_w[1];
      c_side_q.new_z      <= sat_w[2];
      c_side_q.new_angle  <= sat_w[3];
      c_side_q.new_age    <= b_age_q;
      c_side_q.keep       <= b_keep_q;
      c_side_q.shown      <= !b_age_q[W-1];
      c_side_q.start_size <= b_s0_q;
      c_side_q.end_size   <= b_s1_q;
      // Only meaningful when 0 <= new age < life; otherwise the quotient is unused.
      c_rem_q             <= b_age_q[UW-1:0];
      c_life_q            <= b_life_q;
    end
  end

  // ---------------- divider: progress = age * 2^FB / life ----------------
  logic           d_v;
  logic [FB-1:0]  d_quo;
  logic [$bits(pfd_pkg::side_t)-1:0] d_side_raw;
  pfd_pkg::side_t d_side;

  pfd_div #(
    .SIDE_W ($bits(pfd_pkg::side_t)),
    .QW     (FB),
    .DW     (UW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (c_v_q),
    .rem_i   (c_rem_q),
    .div_i   (c_life_q),
    .side_i  (c_side_q),
    .valid_o (d_v),
    .quo_o   (d_quo),
    .side_o  (d_side_raw)
  );

  assign d_side = pfd_pkg::side_t'(d_side_raw);

  // ---------------- stage E: blend and square products ----------------
  logic [FB:0]         prog_w;
  logic signed [W-1:0] diff_w;

  // A removed particle has full progress.
  assign prog_w = d_side.keep ? {1'b0, d_quo} : pfd_pkg::ONE_Q;
  assign diff_w = $signed({1'b0, d_side.end_size}) - $signed({1'b0, d_side.start_size});

  logic                   e_v_q;
  pfd_pkg::side_t         e_side_q;
  logic [FB:0]            e_prog_q;
  logic signed [W+FB+1:0] e_dp_q;
  logic [2*FB+1:0]        e_pp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_v_q <= 1'b0;
    end else if (en) begin
      e_v_q <= d_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_side_q <= d_side;
      e_prog_q <= prog_w;
      e_dp_q   <= (W+FB+2)'(diff_w) * (W+FB+2)'($signed({1'b0, prog_w}));
      e_pp_q   <= (2*FB+2)'(prog_w) * (2*FB+2)'(prog_w);
    end
  end

  // ---------------- stage F: size and smoothstep product ----------------
  logic signed [W+FB+1:0] dp_sh;
  logic signed [W+FB+1:0] size_sum;
  logic [FB+1:0]          p2_w;
  logic [17:0]            t_w;
  logic [UW-1:0]          size_w;

  assign dp_sh    = e_dp_q >>> FB;
  assign size_sum = $signed({{(FB+3){1'b0}}, e_side_q.start_size}) + dp_sh;
  assign p2_w     = e_pp_q[2*FB+1:FB];
  assign t_w      = pfd_pkg::THREE_Q - {e_prog_q, 1'b0};

  always_comb begin
    if (size_sum < 0) begin
      size_w = '0;
    end else if (size_sum > (W+FB+2)'(pfd_pkg::WORD_MAX)) begin
      size_w = '1;
    end else begin
      size_w = size_sum[UW-1:0];
    end
  end

  logic           f_v_q;
  pfd_pkg::side_t f_side_q;
  logic [UW-1:0]  f_size_q;
  logic [35:0]    f_sp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_v_q <= 1'b0;
    end else if (en) begin
      f_v_q <= e_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_side_q <= e_side_q;
      f_size_q <= size_w;
      f_sp_q   <= 36'(p2_w) * 36'(t_w);
    end
  end

  // ---------------- stage G: fade, output register ----------------
  logic [19:0] s_w;
  logic [16:0] alpha_w;

  assign s_w     = f_sp_q[35:FB];
  assign alpha_w = (s_w > 20'(pfd_pkg::ONE_Q)) ? '0 : 17'(pfd_pkg::ONE_Q - s_w[16:0]);

  logic          out_valid_q;
  pfd_pkg::out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= f_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.new_x       <= f_side_q.new_x;
      out_q.new_y       <= f_side_q.new_y;
      out_q.new_z       <= f_side_q.new_z;
      out_q.new_angle   <= f_side_q.new_angle;
      out_q.new_age     <= f_side_q.new_age;
      out_q.keep        <= f_side_q.keep;
      out_q.shown       <= f_side_q.shown;
      // Hidden particles draw nothing.
      out_q.draw_size   <= f_side_q.shown ? f_size_q : '0;
      out_q.alpha_scale <= f_side_q.shown ? alpha_w : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/core/pfd_checker.sv
`timescale 1ns / 1ps

module pfd_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input pfd_pkg::out_t out_data_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("held output word changed");

  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held output");

  a_hidden: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.shown |->
      out_data_o.draw_size == '0 && out_data_o.alpha_scale == '0)
    else $error("hidden particle has size or alpha");

  a_removed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.keep |-> out_data_o.alpha_scale == '0)
    else $error("removed particle not faded out");

  a_shown_age: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.shown == !out_data_o.new_age[pfd_pkg::WORD_W-1])
    else $error("shown flag disagrees with age sign");

endmodule

bind particle_step_and_fade pfd_checker u_pfd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
